### src/asa_pkg.sv
package asa_pkg;

  localparam int COORD_W = 32;
  localparam int SPEED_W = 31;
  localparam int DIFF_W = COORD_W + 1;
  localparam int FRAC_BITS_DEF = 16;
  localparam int RADIUS_RESET_INT = 10;

  localparam logic [COORD_W-1:0] ACC_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] ACC_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic CMD_APPLY = 1'b0;
  localparam logic CMD_STOP = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] accel_x;
    logic signed [COORD_W-1:0] accel_y;
    logic signed [COORD_W-1:0] accel_z;
    logic                      command;
    logic                      saturated;
  } out_item_t;

endpackage

### src/asa_if.sv
interface asa_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [asa_pkg::COORD_W-1:0]     target_x;
  logic signed [asa_pkg::COORD_W-1:0]     target_y;
  logic signed [asa_pkg::COORD_W-1:0]     target_z;
  logic signed [asa_pkg::COORD_W-1:0]     pos_x;
  logic signed [asa_pkg::COORD_W-1:0]     pos_y;
  logic signed [asa_pkg::COORD_W-1:0]     pos_z;
  logic signed [asa_pkg::COORD_W-1:0]     vel_x;
  logic signed [asa_pkg::COORD_W-1:0]     vel_y;
  logic signed [asa_pkg::COORD_W-1:0]     vel_z;
  logic        [asa_pkg::SPEED_W-1:0]     max_speed;
  logic        [asa_pkg::SPEED_W-1:0]     time_step;
  logic                                   seek_enabled;

  modport source (output valid, target_x, target_y, target_z, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, max_speed, time_step, seek_enabled,
                  input ready);
  modport sink (input valid, target_x, target_y, target_z, pos_x, pos_y, pos_z,
                vel_x, vel_y, vel_z, max_speed, time_step, seek_enabled,
                output ready);
endinterface

interface asa_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [asa_pkg::COORD_W-1:0] accel_x;
  logic signed [asa_pkg::COORD_W-1:0] accel_y;
  logic signed [asa_pkg::COORD_W-1:0] accel_z;
  logic                               command;
  logic                               saturated;

  modport source (output valid, accel_x, accel_y, accel_z, command, saturated,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, command, saturated,
                output ready);
endinterface

interface asa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [asa_pkg::SPEED_W-1:0]    slowing_radius;

  modport source (output valid, slowing_radius, input ready);
  modport sink (input valid, slowing_radius, output ready);
endinterface

### src/arrive_steering_accel_top.sv
// Arrive steering acceleration, one agent per input transfer.
// in_ch carries target, position and velocity vectors, maximum speed, time
// step and the seek flag; out_ch returns one result per input transfer, in
// order: three saturated acceleration components, a command bit and a
// saturation flag. cfg_ch writes the slowing radius; it is always ready and
// must only be written while no agent is in flight.
// A result shows on out_ch from the output buffer and can transfer at the
// next edge. The pipeline takes one agent per cycle while the output buffer
// is not full: the square root resolves one root bit per stage over 34
// stages, and every divider resolves one quotient bit per stage (31, 31 and
// 32 stages on the three divider chains).
// Reset clears every valid bit and the output buffer and loads the radius
// with 10.0. Results land in a two-entry output buffer; the pipeline keeps
// moving while one result waits there. Only when both entries are full does
// the whole pipeline hold and in_ch.ready drop, so no agent is lost or
// repeated while the receiver stalls.
module arrive_steering_accel_top #(
  parameter int FRAC_BITS = asa_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  asa_in_if.sink     in_ch,
  asa_out_if.source  out_ch,
  asa_cfg_if.sink    cfg_ch
);
  localparam int CW = asa_pkg::COORD_W;
  localparam int SPW = asa_pkg::SPEED_W;
  localparam int DW = asa_pkg::DIFF_W;
  localparam int SQ_W = 2 * DW;
  localparam int RAD_W = SQ_W + 2;
  localparam int LEN_W = RAD_W / 2;
  localparam int P1_W = SPW + LEN_W;
  localparam int P2_W = 2 * CW;
  localparam int N3_W = DW + FRAC_BITS;
  localparam int CMP_W = 64;

  typedef struct packed {
    logic signed [DW-1:0] d_x;
    logic signed [DW-1:0] d_y;
    logic signed [DW-1:0] d_z;
    logic signed [CW-1:0] v_x;
    logic signed [CW-1:0] v_y;
    logic signed [CW-1:0] v_z;
    logic [SPW-1:0]       vmax;
    logic [SPW-1:0]       dt;
    logic                 seek;
  } sq_sb_t;

  typedef struct packed {
    sq_sb_t            base;
    logic [LEN_W-1:0]  len;
    logic              less;
  } d1_sb_t;

  // The whole pipeline advances together; it holds only when the output
  // buffer is full.
  logic [1:0] cnt_r;
  logic       en;
  assign en = (cnt_r != 2'd2);
  assign in_ch.ready = en;

  // Slowing radius register.
  logic [SPW-1:0] radius_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= SPW'(asa_pkg::RADIUS_RESET_INT) << FRAC_BITS;
    end else if (cfg_ch.valid) begin
      radius_r <= cfg_ch.slowing_radius;
    end
  end

  // Stage A: offset vector.
  logic   a_vld_r;
  sq_sb_t a_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_r.d_x <= DW'(in_ch.target_x) - DW'(in_ch.pos_x);
      a_r.d_y <= DW'(in_ch.target_y) - DW'(in_ch.pos_y);
      a_r.d_z <= DW'(in_ch.target_z) - DW'(in_ch.pos_z);
      a_r.v_x <= in_ch.vel_x;
      a_r.v_y <= in_ch.vel_y;
      a_r.v_z <= in_ch.vel_z;
      a_r.vmax <= in_ch.max_speed;
      a_r.dt <= in_ch.time_step;
      a_r.seek <= in_ch.seek_enabled;
    end
  end

  // Stage B: squares of the offset magnitudes.
  logic [DW-1:0]   a_mag [3];
  always_comb begin
    a_mag[0] = a_r.d_x[DW-1] ? DW'(-a_r.d_x) : DW'(a_r.d_x);
    a_mag[1] = a_r.d_y[DW-1] ? DW'(-a_r.d_y) : DW'(a_r.d_y);
    a_mag[2] = a_r.d_z[DW-1] ? DW'(-a_r.d_z) : DW'(a_r.d_z);
  end

  logic            b_vld_r;
  sq_sb_t          b_r;
  logic [SQ_W-1:0] b_sq_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_r <= a_r;
      for (int c = 0; c < 3; c++) begin
        b_sq_r[c] <= SQ_W'(a_mag[c]) * SQ_W'(a_mag[c]);
      end
    end
  end

  // Stage C: sum of squares. Three squares of 33-bit values stay below 2^66.
  logic            c_vld_r;
  sq_sb_t          c_r;
  logic [SQ_W-1:0] c_sum_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= b_r;
      c_sum_r <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
    end
  end

  // Square root of the summed squares gives the floor of the length.
  logic             sq_vld;
  logic [LEN_W-1:0] sq_len;
  sq_sb_t           sq_sb;
  asa_sqrt_pipe #(
    .RAD_W (RAD_W),
    .SW    ($bits(sq_sb_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (c_vld_r),
    .in_rad   ({2'b00, c_sum_r}),
    .in_sb    (c_r),
    .out_vld  (sq_vld),
    .out_root (sq_len),
    .out_sb   (sq_sb)
  );

  // Stage D: decide whether the agent is inside the slowing radius and form
  // max_speed * length for the speed ramp.
  logic            d_vld_r;
  d1_sb_t          d_r;
  logic [P1_W-1:0] d_prod_r;
  logic            d_less;
  assign d_less = (sq_len < LEN_W'(radius_r));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= sq_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_r.base <= sq_sb;
      d_r.len <= sq_len;
      d_r.less <= d_less;
      // Outside the radius the quotient is not used; a zero numerator keeps
      // the divider within its range.
      d_prod_r <= d_less ? P1_W'(sq_sb.vmax) * P1_W'(sq_len) : '0;
    end
  end

  // Ramped speed: quotient below max_speed, so 31 bits suffice.
  logic           dv1_vld;
  logic [SPW-1:0] dv1_q;
  d1_sb_t         dv1_sb;
  asa_div_pipe #(
    .NUM_W (P1_W),
    .DEN_W (SPW),
    .QUO_W (SPW),
    .SW    ($bits(d1_sb_t))
  ) u_div_speed (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (d_vld_r),
    .in_num  (d_prod_r),
    .in_den  (radius_r),
    .in_sb   (d_r),
    .out_vld (dv1_vld),
    .out_quo (dv1_q),
    .out_sb  (dv1_sb)
  );

  // Stage E: pick the desired speed and scale each offset magnitude by it.
  logic [SPW-1:0]   e_speed;
  logic [DW-1:0]    e_mag [3];
  logic             e_sgn [3];
  always_comb begin
    e_speed = dv1_sb.less ? dv1_q : dv1_sb.base.vmax;
    e_sgn[0] = dv1_sb.base.d_x[DW-1];
    e_sgn[1] = dv1_sb.base.d_y[DW-1];
    e_sgn[2] = dv1_sb.base.d_z[DW-1];
    e_mag[0] = e_sgn[0] ? DW'(-dv1_sb.base.d_x) : DW'(dv1_sb.base.d_x);
    e_mag[1] = e_sgn[1] ? DW'(-dv1_sb.base.d_y) : DW'(dv1_sb.base.d_y);
    e_mag[2] = e_sgn[2] ? DW'(-dv1_sb.base.d_z) : DW'(dv1_sb.base.d_z);
  end

  logic                 e_vld_r;
  logic [P2_W-1:0]      e_prod_r [3];
  logic                 e_sgn_r  [3];
  logic signed [CW-1:0] e_v_r    [3];
  logic [LEN_W-1:0]     e_den_r;
  logic [SPW-1:0]       e_dt_r;
  logic                 e_seek_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= dv1_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        e_prod_r[c] <= P2_W'(e_mag[c]) * P2_W'(e_speed);
        e_sgn_r[c] <= e_sgn[c];
      end
      e_v_r[0] <= dv1_sb.base.v_x;
      e_v_r[1] <= dv1_sb.base.v_y;
      e_v_r[2] <= dv1_sb.base.v_z;
      // A zero length only happens with a zero offset, whose product is zero.
      e_den_r <= (dv1_sb.len == '0) ? LEN_W'(1) : dv1_sb.len;
      e_dt_r <= dv1_sb.base.dt;
      e_seek_r <= dv1_sb.base.seek;
    end
  end

  // Desired velocity magnitude per component: |d| * speed / length.
  logic                 dv2_vld [3];
  logic [SPW-1:0]       dv2_q   [3];
  logic                 f_sgn   [3];
  logic signed [CW-1:0] f_v     [3];
  logic [SPW-1:0]       f_dt;
  logic                 f_seek;

  for (genvar c = 0; c < 3; c++) begin : g_div_vel
    localparam int SBW = (c == 0) ? (1 + CW + SPW + 1) : (1 + CW);
    logic [SBW-1:0] sb_i;
    logic [SBW-1:0] sb_o;
    if (c == 0) begin : g_lead
      assign sb_i = {e_sgn_r[c], e_v_r[c], e_dt_r, e_seek_r};
      assign f_dt = sb_o[SPW:1];
      assign f_seek = sb_o[0];
    end else begin : g_rest
      assign sb_i = {e_sgn_r[c], e_v_r[c]};
    end
    asa_div_pipe #(
      .NUM_W (P2_W),
      .DEN_W (LEN_W),
      .QUO_W (SPW),
      .SW    (SBW)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (e_vld_r),
      .in_num  (e_prod_r[c]),
      .in_den  (e_den_r),
      .in_sb   (sb_i),
      .out_vld (dv2_vld[c]),
      .out_quo (dv2_q[c]),
      .out_sb  (sb_o)
    );
    assign f_sgn[c] = sb_o[SBW-1];
    assign f_v[c] = sb_o[SBW-2 -: CW];
  end

  // Stage F: steering = desired velocity - current velocity, 33 bits.
  logic signed [CW-1:0] f_want [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      f_want[c] = f_sgn[c] ? -$signed({1'b0, dv2_q[c]}) : $signed({1'b0, dv2_q[c]});
    end
  end

  logic                 f_vld_r;
  logic signed [DW-1:0] f_steer_r [3];
  logic [SPW-1:0]       f_dt_r;
  logic                 f_seek_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= dv2_vld[0];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        f_steer_r[c] <= DW'(f_want[c]) - DW'(f_v[c]);
      end
      f_dt_r <= f_dt;
      f_seek_r <= f_seek;
    end
  end

  // Stage G: scale the steering magnitude by 2^FRAC_BITS and flag quotients
  // that cannot fit in 32 bits. A zero time step overflows any nonzero
  // steering component; a zero one divides cleanly by one.
  logic [DW-1:0]   g_mag [3];
  logic [N3_W-1:0] g_num [3];
  logic            g_ovf [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      g_mag[c] = f_steer_r[c][DW-1] ? DW'(-f_steer_r[c]) : DW'(f_steer_r[c]);
      g_num[c] = N3_W'(g_mag[c]) << FRAC_BITS;
      g_ovf[c] = (f_steer_r[c] != '0) &&
                 (CMP_W'(g_num[c]) >= {1'b0, f_dt_r, {CW{1'b0}}});
    end
  end

  logic            g_vld_r;
  logic [N3_W-1:0] g_num_r [3];
  logic            g_sgn_r [3];
  logic            g_ovf_r [3];
  logic [SPW-1:0]  g_den_r;
  logic            g_seek_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= f_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        g_num_r[c] <= g_ovf[c] ? '0 : g_num[c];
        g_sgn_r[c] <= f_steer_r[c][DW-1];
        g_ovf_r[c] <= g_ovf[c];
      end
      g_den_r <= (f_dt_r == '0) ? SPW'(1) : f_dt_r;
      g_seek_r <= f_seek_r;
    end
  end

  // Acceleration magnitude per component.
  logic          dv3_vld [3];
  logic [CW-1:0] dv3_q   [3];
  logic          h_sgn   [3];
  logic          h_ovf   [3];
  logic          h_seek;

  for (genvar c = 0; c < 3; c++) begin : g_div_acc
    localparam int SBW = (c == 0) ? 3 : 2;
    logic [SBW-1:0] sb_i;
    logic [SBW-1:0] sb_o;
    if (c == 0) begin : g_lead
      assign sb_i = {g_sgn_r[c], g_ovf_r[c], g_seek_r};
      assign h_seek = sb_o[0];
    end else begin : g_rest
      assign sb_i = {g_sgn_r[c], g_ovf_r[c]};
    end
    asa_div_pipe #(
      .NUM_W (N3_W),
      .DEN_W (SPW),
      .QUO_W (CW),
      .SW    (SBW)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (g_vld_r),
      .in_num  (g_num_r[c]),
      .in_den  (g_den_r),
      .in_sb   (sb_i),
      .out_vld (dv3_vld[c]),
      .out_quo (dv3_q[c]),
      .out_sb  (sb_o)
    );
    assign h_sgn[c] = sb_o[SBW-1];
    assign h_ovf[c] = sb_o[SBW-2];
  end

  // Final stage: sign, clip and assemble the result item.
  logic [CW-1:0]      h_acc [3];
  logic               h_clip [3];
  asa_pkg::out_item_t h_item;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!h_sgn[c]) begin
        h_clip[c] = h_ovf[c] || dv3_q[c][CW-1];
        h_acc[c] = h_clip[c] ? asa_pkg::ACC_MAX : dv3_q[c];
      end else begin
        h_clip[c] = h_ovf[c] || (dv3_q[c] > asa_pkg::ACC_MIN);
        h_acc[c] = h_clip[c] ? asa_pkg::ACC_MIN : CW'(-dv3_q[c]);
      end
    end
    if (h_seek) begin
      h_item.accel_x = h_acc[0];
      h_item.accel_y = h_acc[1];
      h_item.accel_z = h_acc[2];
      h_item.command = asa_pkg::CMD_APPLY;
      h_item.saturated = h_clip[0] || h_clip[1] || h_clip[2];
    end else begin
      // Seeking off: only a velocity stop is commanded.
      h_item.accel_x = '0;
      h_item.accel_y = '0;
      h_item.accel_z = '0;
      h_item.command = asa_pkg::CMD_STOP;
      h_item.saturated = 1'b0;
    end
  end

  // Two-entry output buffer; the head entry drives out_ch.
  asa_pkg::out_item_t buf_r [2];
  logic push;
  logic pop;
  assign push = en && dv3_vld[0];
  assign pop = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf_r[0] <= (push && cnt_r == 2'd1) ? h_item : buf_r[1];
    end else if (push && cnt_r == 2'd0) begin
      buf_r[0] <= h_item;
    end
    if (push && ((cnt_r == 2'd1 && !pop) || (cnt_r == 2'd2))) begin
      buf_r[1] <= h_item;
    end
  end

  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.accel_x = buf_r[0].accel_x;
  assign out_ch.accel_y = buf_r[0].accel_y;
  assign out_ch.accel_z = buf_r[0].accel_z;
  assign out_ch.command = buf_r[0].command;
  assign out_ch.saturated = buf_r[0].saturated;

  // The buffer never holds more than its two entries.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  // The three velocity dividers move in lockstep.
  a_vel_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (dv2_vld[0] == dv2_vld[1]) && (dv2_vld[0] == dv2_vld[2]))
    else $error("velocity dividers out of step");

  // The three acceleration dividers move in lockstep.
  a_acc_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (dv3_vld[0] == dv3_vld[1]) && (dv3_vld[0] == dv3_vld[2]))
    else $error("acceleration dividers out of step");

  // A stop command carries zero acceleration and no saturation flag.
  a_stop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.command == asa_pkg::CMD_STOP) |->
      (out_ch.accel_x == '0 && out_ch.accel_y == '0 && out_ch.accel_z == '0 &&
       !out_ch.saturated))
    else $error("stop command with nonzero payload");

  // A held pipeline takes no new transfer into the output buffer.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> (cnt_r == 2'd2))
    else $error("output buffer changed while full and stalled");
endmodule

### src/asa_sqrt_pipe.sv
// Pipelined integer square root, one root bit resolved per stage.
module asa_sqrt_pipe #(
  parameter int RAD_W = 68,
  parameter int SW = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [RAD_W-1:0]   in_rad,
  input  logic [SW-1:0]      in_sb,
  output logic               out_vld,
  output logic [RAD_W/2-1:0] out_root,
  output logic [SW-1:0]      out_sb
);
  localparam int RW = RAD_W / 2;
  localparam int REM_W = RW + 2;

  logic [REM_W-1:0] rem_r  [RW];
  logic [RW-1:0]    root_r [RW];
  logic [RAD_W-1:0] rad_r  [RW];
  logic [SW-1:0]    sb_r   [RW];
  logic             vld_r  [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [RW-1:0]    root_in;
    logic [RAD_W-1:0] rad_in;
    logic [SW-1:0]    sb_in;
    logic             vld_in;
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             take;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign root_in = '0;
      assign rad_in = in_rad;
      assign sb_in = in_sb;
      assign vld_in = in_vld;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign rad_in = rad_r[g-1];
      assign sb_in = sb_r[g-1];
      assign vld_in = vld_r[g-1];
    end

    always_comb begin
      cur = {rem_in, rad_in[RAD_W-1 -: 2]};
      trial = {{(REM_W-RW){1'b0}}, root_in, 2'b01};
      take = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= take ? REM_W'(cur - trial) : REM_W'(cur);
        root_r[g] <= {root_in[RW-2:0], take};
        rad_r[g] <= {rad_in[RAD_W-3:0], 2'b00};
        sb_r[g] <= sb_in;
      end
    end
  end

  assign out_vld = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_sb = sb_r[RW-1];
endmodule

### src/asa_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// The numerator must stay below den * 2^QUO_W.
module asa_div_pipe #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int QUO_W = 32,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SW-1:0]    in_sb,
  output logic             out_vld,
  output logic [QUO_W-1:0] out_quo,
  output logic [SW-1:0]    out_sb
);
  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [SW-1:0]    sb_r  [QUO_W];
  logic             vld_r [QUO_W];

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    localparam int SH = QUO_W - 1 - g;
    logic [NUM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [SW-1:0]    sb_in;
    logic             vld_in;
    logic [CW-1:0]    dsh;
    logic             take;

    if (g == 0) begin : g_first
      assign rem_in = in_num;
      assign quo_in = '0;
      assign den_in = in_den;
      assign sb_in = in_sb;
      assign vld_in = in_vld;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign quo_in = quo_r[g-1];
      assign den_in = den_r[g-1];
      assign sb_in = sb_r[g-1];
      assign vld_in = vld_r[g-1];
    end

    always_comb begin
      dsh = CW'(den_in) << SH;
      take = (CW'(rem_in) >= dsh);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= take ? NUM_W'(CW'(rem_in) - dsh) : rem_in;
        quo_r[g] <= {quo_in[QUO_W-2:0], take};
        den_r[g] <= den_in;
        sb_r[g] <= sb_in;
      end
    end
  end

  assign out_vld = vld_r[QUO_W-1];
  assign out_quo = quo_r[QUO_W-1];
  assign out_sb = sb_r[QUO_W-1];
endmodule

### sim/tb_arrive_steering_accel_top.sv
module tb_arrive_steering_accel_top;

  localparam int FRAC = asa_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 135;
  // Limit on cycles without any transfer; covers the long receiver hold-off.
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] tx, ty, tz, px, py, pz, vx, vy, vz;
    logic [30:0] vmax, dt;
    logic seek;
  } agent_t;

  logic clk;
  logic rst_n;

  asa_in_if in_ch();
  asa_out_if out_ch();
  asa_cfg_if cfg_ch();

  arrive_steering_accel_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // The predictor keeps its own copy of the slowing radius.
  logic [30:0] radius_model;
  asa_pkg::out_item_t accel_queue[$];
  int errors;
  int sent;
  int received;
  int saturated_seen;
  int stop_seen;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Floor of the length of a vector, computed bit by bit on wide integers.
  function automatic logic [33:0] vector_length(input logic signed [33:0] dx,
                                                input logic signed [33:0] dy,
                                                input logic signed [33:0] dz);
    logic [69:0] sum;
    logic [33:0] root;
    logic [33:0] trial;
    logic [69:0] sq;
    sum = 70'(dx) * 70'(dx) + 70'(dy) * 70'(dy) + 70'(dz) * 70'(dz);
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = root | (34'd1 << b);
      sq = 70'(trial) * 70'(trial);
      if (sq <= sum) root = trial;
    end
    return root;
  endfunction

  // Divide a steering component by the time step and clip it to 32 bits.
  function automatic logic [31:0] divide_clip(input logic signed [95:0] steer,
                                              input logic [30:0] dt,
                                              inout bit sat);
    logic signed [95:0] q;
    if (dt == 0) begin
      if (steer > 0) begin
        sat = 1'b1;
        return asa_pkg::ACC_MAX;
      end
      if (steer < 0) begin
        sat = 1'b1;
        return asa_pkg::ACC_MIN;
      end
      return '0;
    end
    q = (steer * (96'sd1 <<< FRAC)) / $signed({65'd0, dt});
    if (q > 96'sd2147483647) begin
      sat = 1'b1;
      return asa_pkg::ACC_MAX;
    end
    if (q < -96'sd2147483648) begin
      sat = 1'b1;
      return asa_pkg::ACC_MIN;
    end
    return q[31:0];
  endfunction

  function automatic asa_pkg::out_item_t arrive_accel(input agent_t a);
    asa_pkg::out_item_t r;
    logic signed [95:0] d[3];
    logic signed [95:0] v[3];
    logic signed [95:0] want;
    logic [33:0] len;
    logic [95:0] speed;
    logic [31:0] acc[3];
    bit sat;
    r = '0;
    if (!a.seek) begin
      r.command = asa_pkg::CMD_STOP;
      return r;
    end
    d[0] = 96'(a.tx) - 96'(a.px);
    d[1] = 96'(a.ty) - 96'(a.py);
    d[2] = 96'(a.tz) - 96'(a.pz);
    v[0] = 96'(a.vx);
    v[1] = 96'(a.vy);
    v[2] = 96'(a.vz);
    len = vector_length(d[0][33:0], d[1][33:0], d[2][33:0]);
    speed = 96'(a.vmax);
    if (len < radius_model) speed = (96'(a.vmax) * 96'(len)) / 96'(radius_model);
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (len == 0) want = 0;
      else want = (d[i] * $signed(speed)) / $signed(96'(len));
      acc[i] = divide_clip(want - v[i], a.dt, sat);
    end
    r.accel_x = acc[0];
    r.accel_y = acc[1];
    r.accel_z = acc[2];
    r.command = asa_pkg::CMD_APPLY;
    r.saturated = sat;
    return r;
  endfunction

  // Checker: every result transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    asa_pkg::out_item_t got;
    asa_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.accel_x = out_ch.accel_x;
      got.accel_y = out_ch.accel_y;
      got.accel_z = out_ch.accel_z;
      got.command = out_ch.command;
      got.saturated = out_ch.saturated;
      received++;
      if (got.saturated) saturated_seen++;
      if (got.command == asa_pkg::CMD_STOP) stop_seen++;
      if (accel_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = accel_queue.pop_front();
        if (got.command !== want.command) begin
          $display("%0t: command expected %b actual %b", $time, want.command, got.command);
          errors++;
        end
        if (got.saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   got.saturated);
          errors++;
        end
        // With a stop command the acceleration fields carry no meaning.
        if (want.command == asa_pkg::CMD_APPLY) begin
          if (got.accel_x !== want.accel_x) begin
            $display("%0t: accel_x expected %h actual %h", $time, want.accel_x, got.accel_x);
            errors++;
          end
          if (got.accel_y !== want.accel_y) begin
            $display("%0t: accel_y expected %h actual %h", $time, want.accel_y, got.accel_y);
            errors++;
          end
          if (got.accel_z !== want.accel_z) begin
            $display("%0t: accel_z expected %h actual %h", $time, want.accel_z, got.accel_z);
            errors++;
          end
        end
      end
    end
  end

  // The receiver stalls at random, or holds off entirely during the pressure phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The watchdog ends the run when nothing is transferred for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // One agent transfer: optional idle cycles, then hold valid until accepted.
  // The prediction is queued at the edge of the transfer.
  task automatic send_agent(input agent_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.target_x <= a.tx;
    in_ch.target_y <= a.ty;
    in_ch.target_z <= a.tz;
    in_ch.pos_x <= a.px;
    in_ch.pos_y <= a.py;
    in_ch.pos_z <= a.pz;
    in_ch.vel_x <= a.vx;
    in_ch.vel_y <= a.vy;
    in_ch.vel_z <= a.vz;
    in_ch.max_speed <= a.vmax;
    in_ch.time_step <= a.dt;
    in_ch.seek_enabled <= a.seek;
    do @(posedge clk); while (!in_ch.ready);
    accel_queue.push_back(arrive_accel(a));
    sent++;
  endtask

  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (accel_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // The radius is only written once the pipeline is empty.
  task automatic write_radius(input logic [30:0] r);
    cfg_ch.valid <= 1'b1;
    cfg_ch.slowing_radius <= r;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    radius_model = r;
  endtask

  function automatic logic signed [31:0] rand_coord(input int style);
    case (style)
      0: return $signed($urandom);
      1: return $signed($urandom_range(0, 2 * 65536 * 20)) - 32'sd1310720;
      default: return $signed($urandom_range(0, 4096)) - 32'sd2048;
    endcase
  endfunction

  // Mostly realistic agents near their targets, plus fully random noise.
  function automatic agent_t rand_agent();
    agent_t a;
    int style;
    int pick;
    style = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2);
    a.px = rand_coord(0 + (style == 0 ? 0 : 1));
    a.py = rand_coord(style == 0 ? 0 : 1);
    a.pz = rand_coord(style == 0 ? 0 : 1);
    a.tx = (style == 0) ? rand_coord(0) : a.px + rand_coord(style);
    a.ty = (style == 0) ? rand_coord(0) : a.py + rand_coord(style);
    a.tz = (style == 0) ? rand_coord(0) : a.pz + rand_coord(style);
    if ($urandom_range(0, 19) == 0) begin
      a.tx = a.px;
      a.ty = a.py;
      a.tz = a.pz;
    end
    a.vx = (style == 0) ? rand_coord(0) : rand_coord(1);
    a.vy = (style == 0) ? rand_coord(0) : rand_coord(1);
    a.vz = (style == 0) ? rand_coord(0) : rand_coord(1);
    pick = $urandom_range(0, 9);
    a.vmax = (pick == 0) ? 31'($urandom) : 31'($urandom_range(0, 65536 * 50));
    pick = $urandom_range(0, 19);
    if (pick == 0) a.dt = '0;
    else if (pick == 1) a.dt = 31'($urandom);
    else a.dt = 31'($urandom_range(1, 65536 / 10));
    a.seek = $urandom_range(0, 9) != 0;
    return a;
  endfunction

  function automatic agent_t make_agent(input logic signed [31:0] tx, ty, tz, px, py, pz,
                                        vx, vy, vz, input logic [30:0] vmax, dt,
                                        input logic seek);
    agent_t a;
    a.tx = tx; a.ty = ty; a.tz = tz;
    a.px = px; a.py = py; a.pz = pz;
    a.vx = vx; a.vy = vy; a.vz = vz;
    a.vmax = vmax; a.dt = dt; a.seek = seek;
    return a;
  endfunction

  // The directed table; rows whose result is obvious carry it typed in.
  typedef struct {
    agent_t a;
    bit has_fixed;
    asa_pkg::out_item_t fixed;
  } directed_row_t;

  directed_row_t directed_rows[$];

  task automatic add_row(input agent_t a, input bit has_fixed,
                         input asa_pkg::out_item_t fixed);
    directed_row_t row;
    row.a = a;
    row.has_fixed = has_fixed;
    row.fixed = fixed;
    directed_rows.push_back(row);
  endtask

  task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_agent(rand_agent());
    drain_pipeline();
  endtask

  localparam logic signed [31:0] CMAX = 32'sh7fffffff;
  localparam logic signed [31:0] CMIN = 32'sh80000000;
  localparam logic [30:0] UMAX = 31'h7fffffff;
  localparam logic [30:0] ONE = 31'd65536;

  initial begin
    asa_pkg::out_item_t fx;
    asa_pkg::out_item_t pred;
    int press_count;
    errors = 0;
    sent = 0;
    received = 0;
    saturated_seen = 0;
    stop_seen = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.target_x = '0; in_ch.target_y = '0; in_ch.target_z = '0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.vel_x = '0; in_ch.vel_y = '0; in_ch.vel_z = '0;
    in_ch.max_speed = '0; in_ch.time_step = '0; in_ch.seek_enabled = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.slowing_radius = '0;
    radius_model = 31'(asa_pkg::RADIUS_RESET_INT << FRAC);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Seek disabled: stop command, saturation clear.
    fx = '0;
    fx.command = asa_pkg::CMD_STOP;
    add_row(make_agent(CMAX, CMIN, 5, 0, 0, 0, CMAX, CMIN, 0, UMAX, 0, 1'b0), 1, fx);
    // Zero offset, zero velocity: nothing to steer, zero acceleration.
    fx = '0;
    add_row(make_agent(7, 7, 7, 7, 7, 7, 0, 0, 0, UMAX, ONE, 1'b1), 1, fx);
    // Zero time step with positive, negative and zero steering components.
    fx = '0;
    fx.accel_x = asa_pkg::ACC_MIN;
    fx.accel_y = asa_pkg::ACC_MAX;
    fx.saturated = 1'b1;
    add_row(make_agent(0, 0, 0, 0, 0, 0, ONE, -ONE, 0, ONE, 0, 1'b1), 1, fx);
    // Extreme offsets in every direction and extreme velocities, plus a tiny offset.
    add_row(make_agent(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, UMAX, 1, 1), 0, '0);
    add_row(make_agent(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, UMAX, 1, 1), 0, '0);
    add_row(make_agent(CMIN, CMAX, 0, CMAX, CMIN, 0, 0, 0, 0, UMAX, UMAX, 1), 0, '0);
    add_row(make_agent(-1, -1, -1, 0, 0, 0, -1, -1, -1, 1, UMAX, 1), 0, '0);
    // Inside and outside the slowing radius, on its edge.
    add_row(make_agent(ONE * 3, 0, 0, 0, 0, 0, 0, 0, 0, ONE * 5, ONE, 1), 0, '0);
    add_row(make_agent(ONE * 10, 0, 0, 0, 0, 0, 0, 0, 0, ONE * 5, ONE, 1), 0, '0);
    add_row(make_agent(ONE * 10 - 1, 0, 0, 0, 0, 0, 0, 0, 0, ONE * 5, ONE, 1), 0, '0);
    add_row(make_agent(0, ONE * 300, -ONE * 40, 0, 0, 0, ONE, 2, 3, ONE * 8, ONE / 60, 1),
            0, '0);
    add_row(make_agent(0, 0, ONE * 2, 0, 0, 0, 0, 0, 0, 0, ONE, 1), 0, '0);
    add_row(make_agent(5, -3, 1, 0, 0, 0, 0, 0, 0, UMAX, 1, 1), 0, '0);

    foreach (directed_rows[i]) begin
      pred = arrive_accel(directed_rows[i].a);
      if (directed_rows[i].has_fixed && pred != directed_rows[i].fixed) begin
        $display("%0t: table row %0d expected %h predictor %h", $time, i,
                 directed_rows[i].fixed, pred);
        errors++;
      end
      send_agent(directed_rows[i].a);
    end
    drain_pipeline();

    // Random traffic under each idling pattern, with the radius changed between phases.
    random_phase(80, 0, 0);
    write_radius(31'd1);
    random_phase(80, 51, 0);
    write_radius(UMAX);
    random_phase(80, 0, 51);
    write_radius(31'd0);
    random_phase(60, 18, 18);
    write_radius(31'($urandom_range(ONE, ONE * 40)));
    random_phase(80, 18, 18);

    // Back-pressure: the receiver holds off while agents keep coming, long
    // enough that the pipeline and the output buffer fill and the input stalls.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (LATENCY * 2 + 50) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        press_count = 0;
        while (press_count < 160) begin
          send_agent(rand_agent());
          press_count++;
        end
      end
    join
    drain_pipeline();
    write_radius(31'(asa_pkg::RADIUS_RESET_INT << FRAC));
    random_phase(80, 0, 0);

    $display("Covered %0d agent transfers, %0d results (%0d saturated, %0d stop commands),",
             sent, received, saturated_seen, stop_seen);
    $display("across five slowing radii and four idling patterns plus a long receiver stall.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### arrive_steering_accel_top.f
src/asa_pkg.sv
src/asa_if.sv
src/asa_sqrt_pipe.sv
src/asa_div_pipe.sv
src/arrive_steering_accel_top.sv
sim/tb_arrive_steering_accel_top.sv
